// ----- src/sgce_pkg.sv -----
// shared types, constants and corner tables for the grid cell to elements block
package sgce_pkg;

  localparam int unsigned AXIS_W = 10;
  localparam int unsigned NODE_W = 30;
  localparam int unsigned ID_W = 33;
  localparam int unsigned TYPE_W = 3;
  localparam int unsigned TETS_PER_CELL = 5;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  localparam logic [TYPE_W-1:0] TYPE_TET = 3'd4;
  localparam logic [TYPE_W-1:0] TYPE_HEX = 3'd5;
  localparam logic [2:0] LAST_TET = 3'(TETS_PER_CELL - 1);

  typedef enum logic [1:0] {
    CFG_CELLS_X  = 2'd0,
    CFG_CELLS_Y  = 2'd1,
    CFG_CELLS_Z  = 2'd2,
    CFG_HEX_MODE = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [AXIS_W-1:0] cells_x;
    logic [AXIS_W-1:0] cells_y;
    logic [AXIS_W-1:0] cells_z;
    logic              hex_mode;
  } cfg_t;

  typedef struct packed {
    logic [AXIS_W-1:0] cell_x;
    logic [AXIS_W-1:0] cell_y;
    logic [AXIS_W-1:0] cell_z;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0]   element_id;
    logic [TYPE_W-1:0] element_type;
    logic [NODE_W-1:0] corner_0;
    logic [NODE_W-1:0] corner_1;
    logic [NODE_W-1:0] corner_2;
    logic [NODE_W-1:0] corner_3;
    logic [NODE_W-1:0] corner_4;
    logic [NODE_W-1:0] corner_5;
    logic [NODE_W-1:0] corner_6;
    logic [NODE_W-1:0] corner_7;
    logic              last_of_cell;
    logic              out_of_range;
  } out_item_t;

  typedef struct packed {
    logic [7:0][NODE_W-1:0] corners;
    logic [ID_W-1:0]        id_base;
    logic                   odd;
    logic                   hex;
    logic                   oor;
  } cell_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

  localparam logic [2:0] TET_EVEN [TETS_PER_CELL][4] = '{
    '{3'd0, 3'd1, 3'd2, 3'd5},
    '{3'd0, 3'd2, 3'd3, 3'd7},
    '{3'd0, 3'd4, 3'd5, 3'd7},
    '{3'd2, 3'd5, 3'd6, 3'd7},
    '{3'd0, 3'd2, 3'd5, 3'd7}
  };

  localparam logic [2:0] TET_ODD [TETS_PER_CELL][4] = '{
    '{3'd0, 3'd1, 3'd3, 3'd4},
    '{3'd1, 3'd2, 3'd3, 3'd6},
    '{3'd1, 3'd4, 3'd5, 3'd6},
    '{3'd3, 3'd4, 3'd6, 3'd7},
    '{3'd1, 3'd3, 3'd4, 3'd6}
  };

  function automatic logic [2:0] tet_corner(input logic odd, input logic [2:0] k,
                                            input logic [1:0] j);
    logic [2:0] sel;
    if (odd) begin
      sel = TET_ODD[k][j];
    end else begin
      sel = TET_EVEN[k][j];
    end
    return sel;
  endfunction

endpackage

// ----- src/sgce_front.sv -----
// front end: request intake, range check, parity and corner node arithmetic
module sgce_front (
  input  logic                     clk,
  input  logic                     rst,
  input  sgce_pkg::cfg_t           cfg,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  sgce_pkg::in_item_t       in_data,
  output logic                     push,
  output sgce_pkg::cell_entry_t    push_data,
  input  sgce_pkg::queue_status_t  qstat
);

  logic                  v1, v2, v3;
  logic                  rdy1, rdy2, rdy3;
  sgce_pkg::in_item_t    s1;

  logic [9:0]            s2_x, s2_y;
  logic [20:0]           s2_p, s2_s;
  logic [19:0]           s2_q;
  logic                  s2_oor, s2_odd;

  logic [29:0]           s3_v0;
  logic [30:0]           s3_l;
  logic [20:0]           s3_s;
  logic                  s3_oor, s3_odd, s3_hex;

  logic [10:0]           nxp1, nyp1;
  logic [20:0]           r, q;
  logic [29:0]           v4, nxp1_w;
  logic [32:0]           l_w;

  assign nxp1 = {1'b0, cfg.cells_x} + 11'd1;
  assign nyp1 = {1'b0, cfg.cells_y} + 11'd1;

  assign rdy3 = !v3 || !qstat.full;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign in_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  // stage 1: request register
  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) s1 <= in_data;
  end

  // stage 2: products of the cell counts, range check and parity
  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      s2_x   <= s1.cell_x;
      s2_y   <= s1.cell_y;
      s2_p   <= {10'd0, nyp1} * {11'd0, s1.cell_z};
      s2_q   <= {10'd0, cfg.cells_y} * {10'd0, s1.cell_z};
      s2_s   <= {10'd0, nxp1} * {10'd0, nyp1};
      s2_oor <= (s1.cell_x >= cfg.cells_x) || (s1.cell_y >= cfg.cells_y) ||
                (s1.cell_z >= cfg.cells_z);
      s2_odd <= s1.cell_x[0] ^ s1.cell_y[0] ^ s1.cell_z[0];
    end
  end

  assign r = {11'd0, s2_y} + s2_p;
  assign q = {11'd0, s2_y} + {1'b0, s2_q};

  // stage 3: first corner node and linear cell index
  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      s3_v0  <= ({19'd0, nxp1} * {9'd0, r}) + {20'd0, s2_x};
      s3_l   <= ({21'd0, cfg.cells_x} * {10'd0, q}) + {21'd0, s2_x};
      s3_s   <= s2_s;
      s3_oor <= s2_oor;
      s3_odd <= s2_odd;
      s3_hex <= cfg.hex_mode;
    end
  end

  assign nxp1_w = {19'd0, nxp1};
  assign v4     = s3_v0 + {9'd0, s3_s};
  assign l_w    = {2'd0, s3_l};

  always_comb begin
    push_data.corners[0] = s3_v0;
    push_data.corners[1] = s3_v0 + 30'd1;
    push_data.corners[2] = s3_v0 + nxp1_w + 30'd1;
    push_data.corners[3] = s3_v0 + nxp1_w;
    push_data.corners[4] = v4;
    push_data.corners[5] = v4 + 30'd1;
    push_data.corners[6] = v4 + nxp1_w + 30'd1;
    push_data.corners[7] = v4 + nxp1_w;
    push_data.id_base    = s3_hex ? l_w : ({l_w[30:0], 2'b00} + l_w);
    push_data.odd        = s3_odd;
    push_data.hex        = s3_hex;
    push_data.oor        = s3_oor;
  end

  assign push = v3 && !qstat.full;

endmodule

// ----- src/sgce_queue.sv -----
// short queue of classified cells between front and back ends
module sgce_queue (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  sgce_pkg::cell_entry_t    push_data,
  input  logic                     pop,
  output sgce_pkg::cell_entry_t    head,
  output sgce_pkg::queue_status_t  qstat
);

  sgce_pkg::cell_entry_t                entries [sgce_pkg::QUEUE_DEPTH];
  logic [sgce_pkg::QUEUE_PTR_W-1:0]     wr_ptr, rd_ptr;
  logic [sgce_pkg::QUEUE_PTR_W:0]       count;

  assign qstat.empty = (count == '0);
  assign qstat.full  = (count == (sgce_pkg::QUEUE_PTR_W+1)'(sgce_pkg::QUEUE_DEPTH));
  assign head        = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- src/sgce_back.sv -----
// back end: expands one queued cell into its element results
module sgce_back (
  input  logic                     clk,
  input  logic                     rst,
  input  sgce_pkg::cell_entry_t    head,
  input  sgce_pkg::queue_status_t  qstat,
  output logic                     pop,
  output logic                     out_valid,
  input  logic                     out_stall,
  output sgce_pkg::out_item_t      out_data
);

  logic [2:0]           k;
  logic                 load, last;
  sgce_pkg::out_item_t  res;

  assign load = !qstat.empty && (!out_valid || !out_stall);
  assign last = head.oor || head.hex || (k == sgce_pkg::LAST_TET);
  assign pop  = load && last;

  always_comb begin
    res = '0;
    res.last_of_cell = last;
    if (head.oor) begin
      res.element_type = head.hex ? sgce_pkg::TYPE_HEX : sgce_pkg::TYPE_TET;
      res.out_of_range = 1'b1;
    end else if (head.hex) begin
      res.element_id   = head.id_base;
      res.element_type = sgce_pkg::TYPE_HEX;
      res.corner_0     = head.corners[0];
      res.corner_1     = head.corners[1];
      res.corner_2     = head.corners[2];
      res.corner_3     = head.corners[3];
      res.corner_4     = head.corners[4];
      res.corner_5     = head.corners[5];
      res.corner_6     = head.corners[6];
      res.corner_7     = head.corners[7];
    end else begin
      res.element_id   = head.id_base + {30'd0, k};
      res.element_type = sgce_pkg::TYPE_TET;
      res.corner_0     = head.corners[sgce_pkg::tet_corner(head.odd, k, 2'd0)];
      res.corner_1     = head.corners[sgce_pkg::tet_corner(head.odd, k, 2'd1)];
      res.corner_2     = head.corners[sgce_pkg::tet_corner(head.odd, k, 2'd2)];
      res.corner_3     = head.corners[sgce_pkg::tet_corner(head.odd, k, 2'd3)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        k         <= last ? 3'd0 : k + 3'd1;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_data <= res;
  end

  a_k_bound: assert property (@(posedge clk) disable iff (rst)
    k <= sgce_pkg::LAST_TET)
    else $error("element counter past last tetrahedron");

  a_k_advance: assert property (@(posedge clk) disable iff (rst)
    load && !last |=> k != 3'd0)
    else $error("element counter did not advance within a cell");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    qstat.empty |-> !pop)
    else $error("pop from empty queue");

endmodule

// ----- src/structured_grid_cell_to_elements_core.sv -----
// top level: configuration registers, front end, queue and back end
// path to first result: request, product and corner registers, queue, output register
// throughput: one result per cycle while out_stall is low; a tetrahedron cell gives
//   five, a hexahedron or out of range cell one, through the single output register
// a 4-entry cell queue lets intake continue while results drain
// reset: synchronous, clears pipeline valids, queue and counter; grid 1x1x1, tetrahedra
module structured_grid_cell_to_elements_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [1:0]           cfg_index,
  input  logic [9:0]           cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sgce_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sgce_pkg::out_item_t  out_data
);

  sgce_pkg::cfg_t           cfg;
  sgce_pkg::cell_entry_t    push_data, head;
  sgce_pkg::queue_status_t  qstat;
  logic                     push, pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cells_x  <= 10'd1;
      cfg.cells_y  <= 10'd1;
      cfg.cells_z  <= 10'd1;
      cfg.hex_mode <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        sgce_pkg::CFG_CELLS_X:  cfg.cells_x  <= cfg_data;
        sgce_pkg::CFG_CELLS_Y:  cfg.cells_y  <= cfg_data;
        sgce_pkg::CFG_CELLS_Z:  cfg.cells_z  <= cfg_data;
        sgce_pkg::CFG_HEX_MODE: cfg.hex_mode <= cfg_data[0];
        default:                cfg          <= cfg;
      endcase
    end
  end

  sgce_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data),
    .qstat     (qstat)
  );

  sgce_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  sgce_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .qstat     (qstat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- sim/tb_structured_grid_cell_to_elements_core.sv -----
// testbench for the grid cell to elements core: directed and random cells checked per element
module tb_structured_grid_cell_to_elements_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 1000;

  class element_predictor;
    localparam longint unsigned AXIS_MAX = 1023;

    logic [sgce_pkg::AXIS_W-1:0] cells_x = 1;
    logic [sgce_pkg::AXIS_W-1:0] cells_y = 1;
    logic [sgce_pkg::AXIS_W-1:0] cells_z = 1;
    logic                        hex_mode = 1'b0;
    sgce_pkg::out_item_t         expected_elements[$];
    int                          errors = 0;

    function int pending();
      return expected_elements.size();
    endfunction

    function logic [sgce_pkg::NODE_W-1:0] node_number(longint unsigned i, longint unsigned j,
                                                      longint unsigned k, longint unsigned nx,
                                                      longint unsigned ny);
      return (sgce_pkg::NODE_W)'(i + (nx + 1) * (j + (ny + 1) * k));
    endfunction

    function void add_cell(sgce_pkg::in_item_t c);
      longint unsigned nx, ny, nz, x, y, z, lin;
      logic [sgce_pkg::NODE_W-1:0] v[8];
      int even_tets[20];
      int odd_tets[20];
      int tets[20];
      bit [2:0] n;
      int k;
      sgce_pkg::out_item_t e;
      even_tets = '{0, 1, 2, 5, 0, 2, 3, 7, 0, 4, 5, 7, 2, 5, 6, 7, 0, 2, 5, 7};
      odd_tets = '{0, 1, 3, 4, 1, 2, 3, 6, 1, 4, 5, 6, 3, 4, 6, 7, 1, 3, 4, 6};
      nx = (cells_x > AXIS_MAX) ? AXIS_MAX : cells_x;
      ny = (cells_y > AXIS_MAX) ? AXIS_MAX : cells_y;
      nz = (cells_z > AXIS_MAX) ? AXIS_MAX : cells_z;
      x = c.cell_x;
      y = c.cell_y;
      z = c.cell_z;
      e = '0;
      if (x >= nx || y >= ny || z >= nz) begin
        e.element_type = hex_mode ? sgce_pkg::TYPE_HEX : sgce_pkg::TYPE_TET;
        e.last_of_cell = 1'b1;
        e.out_of_range = 1'b1;
        expected_elements.insert(expected_elements.size(), e);
        return;
      end
      for (k = 0; k < 8; k++) begin
        n = 3'(k);
        v[k] = node_number(x + (n[0] ^ n[1]), y + n[1], z + n[2], nx, ny);
      end
      lin = x + nx * (y + ny * z);
      if (hex_mode) begin
        e.element_id = (sgce_pkg::ID_W)'(lin);
        e.element_type = sgce_pkg::TYPE_HEX;
        e.corner_0 = v[0];
        e.corner_1 = v[1];
        e.corner_2 = v[2];
        e.corner_3 = v[3];
        e.corner_4 = v[4];
        e.corner_5 = v[5];
        e.corner_6 = v[6];
        e.corner_7 = v[7];
        e.last_of_cell = 1'b1;
        expected_elements.insert(expected_elements.size(), e);
        return;
      end
      if ((x + y + z) & 1) begin
        tets = odd_tets;
      end else begin
        tets = even_tets;
      end
      for (k = 0; k < 5; k++) begin
        e = '0;
        e.element_id = (sgce_pkg::ID_W)'(lin * 5 + k);
        e.element_type = sgce_pkg::TYPE_TET;
        e.corner_0 = v[tets[4*k]];
        e.corner_1 = v[tets[4*k+1]];
        e.corner_2 = v[tets[4*k+2]];
        e.corner_3 = v[tets[4*k+3]];
        e.last_of_cell = (k == 4);
        expected_elements.insert(expected_elements.size(), e);
      end
    endfunction

    function void check_field(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, actual %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_element(sgce_pkg::out_item_t got);
      sgce_pkg::out_item_t want;
      if (expected_elements.size() == 0) begin
        $error("element_id: expected none, actual %0d", got.element_id);
        errors++;
        return;
      end
      want = expected_elements.pop_front();
      check_field("element_id", want.element_id, got.element_id);
      check_field("element_type", want.element_type, got.element_type);
      check_field("corner_0", want.corner_0, got.corner_0);
      check_field("corner_1", want.corner_1, got.corner_1);
      check_field("corner_2", want.corner_2, got.corner_2);
      check_field("corner_3", want.corner_3, got.corner_3);
      check_field("corner_4", want.corner_4, got.corner_4);
      check_field("corner_5", want.corner_5, got.corner_5);
      check_field("corner_6", want.corner_6, got.corner_6);
      check_field("corner_7", want.corner_7, got.corner_7);
      check_field("last_of_cell", want.last_of_cell, got.last_of_cell);
      check_field("out_of_range", want.out_of_range, got.out_of_range);
    endfunction
  endclass

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  sgce_pkg::cfg_index_t   cfg_index = sgce_pkg::CFG_CELLS_X;
  logic [9:0]             cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  sgce_pkg::in_item_t     in_data = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  sgce_pkg::out_item_t    out_data;

  int in_idle_pct = 6;
  int out_idle_pct = 6;
  int quiet_cycles = 0;

  element_predictor sb = new();

  structured_grid_cell_to_elements_core u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= !rst && ($urandom_range(99) < out_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        sb.add_cell(in_data);
      end
      if (out_valid && !out_stall) begin
        sb.check_element(out_data);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic configure(input logic [9:0] nx, input logic [9:0] ny,
                           input logic [9:0] nz, input logic hex);
    cfg_write <= 1'b1;
    cfg_index <= sgce_pkg::CFG_CELLS_X;
    cfg_data <= nx;
    @(posedge clk);
    cfg_index <= sgce_pkg::CFG_CELLS_Y;
    cfg_data <= ny;
    @(posedge clk);
    cfg_index <= sgce_pkg::CFG_CELLS_Z;
    cfg_data <= nz;
    @(posedge clk);
    cfg_index <= sgce_pkg::CFG_HEX_MODE;
    cfg_data <= {9'd0, hex};
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.cells_x = nx;
    sb.cells_y = ny;
    sb.cells_z = nz;
    sb.hex_mode = hex;
  endtask

  task automatic send_cell(input int unsigned x, input int unsigned y, input int unsigned z);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{cell_x: (sgce_pkg::AXIS_W)'(x), cell_y: (sgce_pkg::AXIS_W)'(y),
                 cell_z: (sgce_pkg::AXIS_W)'(z)};
    do @(posedge clk); while (in_stall);
  endtask

  // hold requests until every element has come out, then let the pipeline settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    int p, n, nx, ny, nz;
    bit hx;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // grid of one cell after reset
    send_cell(0, 0, 0);
    send_cell(1, 0, 0);
    send_cell(1023, 1023, 1023);
    wait_idle();

    configure(1023, 1023, 1023, 1'b0);
    send_cell(0, 0, 0);
    send_cell(1022, 1022, 1022);
    send_cell(1022, 1022, 1021);
    send_cell(1023, 0, 0);
    send_cell(0, 1023, 0);
    send_cell(0, 0, 1023);
    send_cell(1, 0, 0);
    wait_idle();

    configure(1023, 1023, 1023, 1'b1);
    send_cell(0, 0, 0);
    send_cell(1022, 1022, 1022);
    send_cell(1023, 1023, 1023);
    send_cell(5, 700, 300);
    wait_idle();

    // zero count leaves nothing in range
    configure(0, 1023, 1023, 1'b1);
    send_cell(0, 0, 0);
    send_cell(512, 3, 3);
    wait_idle();
    configure(0, 1023, 1023, 1'b0);
    send_cell(0, 0, 0);
    wait_idle();

    for (p = 0; p < 6; p++) begin
      case (p)
        0: begin
          nx = 4; ny = 3; nz = 2; hx = 1'b0;
        end
        1: begin
          nx = $urandom_range(1, 16); ny = $urandom_range(1, 16);
          nz = $urandom_range(1, 16); hx = 1'b1;
        end
        2: begin
          nx = 1023; ny = 1023; nz = 1023; hx = 1'b0;
        end
        3: begin
          nx = $urandom_range(1, 1023); ny = $urandom_range(1, 1023);
          nz = $urandom_range(1, 1023); hx = $urandom_range(1);
        end
        4: begin
          nx = $urandom_range(1, 8); ny = 0; nz = $urandom_range(1, 8); hx = $urandom_range(1);
        end
        default: begin
          nx = 1; ny = 1; nz = 1; hx = 1'b1;
        end
      endcase
      in_idle_pct = (p == 2) ? 0 : 6;
      out_idle_pct = (p == 2) ? 0 : 6;
      configure(10'(nx), 10'(ny), 10'(nz), hx);
      for (n = 0; n < 17; n++) begin
        if (p == 1 && n == 8) begin
          wait_idle();
        end
        if ($urandom_range(99) < 85) begin
          send_cell($urandom_range(nx > 0 ? nx - 1 : 0), $urandom_range(ny > 0 ? ny - 1 : 0),
                    $urandom_range(nz > 0 ? nz - 1 : 0));
        end else begin
          send_cell($urandom_range(1023), $urandom_range(1023), $urandom_range(1023));
        end
      end
      wait_idle();
    end

    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/sgce_pkg.sv
src/sgce_front.sv
src/sgce_queue.sv
src/sgce_back.sv
src/structured_grid_cell_to_elements_core.sv
sim/tb_structured_grid_cell_to_elements_core.sv
